// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the depthwise transposed-conv upsampler.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dtcu_pkg.sv -----
// Package for the depthwise transposed-conv upsampler: sizes, codes and types.
// No dependencies; used by the interfaces, dtcu_mac and the top level.
package dtcu_pkg;

    // Geometry
    localparam int STRIDE    = 16;
    localparam int CHANNELS  = 512;
    localparam int KTAPS     = 2 * STRIDE;
    localparam int PH_W      = $clog2(STRIDE);
    localparam int CH_W      = 9;
    localparam int TAP_W     = 5;
    localparam int MODE_W    = 2;
    localparam int ENT_DEPTH = CHANNELS * STRIDE;
    localparam int ENT_AW    = $clog2(ENT_DEPTH);

    // Arithmetic widths
    localparam int SMP_W  = 16;
    localparam int PROD_W = 2 * SMP_W;
    localparam int RND_SH = 15;
    localparam int OVL_W  = 18;
    localparam int ACC_W  = 20;

    // Request kinds
    typedef enum logic [MODE_W-1:0] {
        MODE_SAMPLE    = 2'd0,
        MODE_LOAD_TAP  = 2'd1,
        MODE_LOAD_BIAS = 2'd2
    } t_mode;

    // Sequencer states
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_RUN   = 2'd2
    } t_state;

    // Bookkeeping that travels with each output beat
    typedef struct packed {
        logic [CH_W-1:0] ch;
        logic [PH_W-1:0] ph;
        logic            last;
    } t_beat;

    // Operands handed to the multiply/accumulate stage
    typedef struct packed {
        logic signed [SMP_W-1:0] val;
        logic signed [SMP_W-1:0] head;
        logic signed [SMP_W-1:0] tail;
        logic signed [OVL_W-1:0] ovl;
        logic signed [SMP_W-1:0] bias;
    } t_ops;

    // Results of the multiply/accumulate stage
    typedef struct packed {
        logic signed [SMP_W-1:0] y;
        logic signed [OVL_W-1:0] ovl;
    } t_res;

endpackage

// ----- design/dtcu_if.sv -----
// Valid/ready stream interfaces for the upsampler's request and result channels.
// Depends on dtcu_pkg for field widths.
interface dtcu_in_if;
    logic                              valid;
    logic                              ready;
    logic [dtcu_pkg::MODE_W-1:0]       mode;
    logic [dtcu_pkg::CH_W-1:0]         channel;
    logic [dtcu_pkg::TAP_W-1:0]        tap_index;
    logic signed [dtcu_pkg::SMP_W-1:0] sample_value;

    modport source (output valid, mode, channel, tap_index, sample_value, input ready);
    modport sink   (input valid, mode, channel, tap_index, sample_value, output ready);
endinterface

interface dtcu_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [dtcu_pkg::SMP_W-1:0] output_sample;
    logic [dtcu_pkg::CH_W-1:0]         out_channel;
    logic [dtcu_pkg::PH_W-1:0]         phase;
    logic                              last_of_run;

    modport source (output valid, output_sample, out_channel, phase, last_of_run, input ready);
    modport sink   (input valid, output_sample, out_channel, phase, last_of_run, output ready);
endinterface

// ----- design/dtcu_mac.sv -----
// Multiply and overlap-add stage: two products per beat, rounding, sum, saturation.
// Depends on dtcu_pkg (t_ops, t_res, widths).
module dtcu_mac (
    input  logic            i_clk,
    input  logic            i_adv,
    input  dtcu_pkg::t_ops  i_ops,
    output dtcu_pkg::t_res  o_res
);

    logic signed [dtcu_pkg::PROD_W-1:0] r_head_p;
    logic signed [dtcu_pkg::PROD_W-1:0] r_tail_p;
    logic signed [dtcu_pkg::OVL_W-1:0]  r_ovl;
    logic signed [dtcu_pkg::SMP_W-1:0]  r_bias;

    logic signed [dtcu_pkg::PROD_W:0]   head_sum;
    logic signed [dtcu_pkg::PROD_W:0]   tail_sum;
    logic signed [dtcu_pkg::OVL_W-1:0]  head_r;
    logic signed [dtcu_pkg::ACC_W-1:0]  acc;
    logic signed [dtcu_pkg::SMP_W-1:0]  y_sat;

    localparam logic signed [dtcu_pkg::PROD_W:0] RND_HALF =
        (dtcu_pkg::PROD_W+1)'(1) <<< (dtcu_pkg::RND_SH - 1);
    localparam logic signed [dtcu_pkg::ACC_W-1:0] Y_MAX =
        dtcu_pkg::ACC_W'((1 << (dtcu_pkg::SMP_W - 1)) - 1);
    localparam logic signed [dtcu_pkg::ACC_W-1:0] Y_MIN = -Y_MAX - 1;

    // Products registered; operands held while the pipeline is stalled
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_head_p <= $signed(i_ops.val) * $signed(i_ops.head);
            r_tail_p <= $signed(i_ops.val) * $signed(i_ops.tail);
            r_ovl    <= i_ops.ovl;
            r_bias   <= i_ops.bias;
        end
    end

    // Round half up to the sample scale: add half an LSB, keep the upper bits
    assign head_sum = (dtcu_pkg::PROD_W+1)'(r_head_p) + RND_HALF;
    assign tail_sum = (dtcu_pkg::PROD_W+1)'(r_tail_p) + RND_HALF;
    assign head_r   = head_sum[dtcu_pkg::PROD_W:dtcu_pkg::RND_SH];

    // Output = head + stored overlap + bias, saturated to the sample range
    assign acc = dtcu_pkg::ACC_W'(head_r) + dtcu_pkg::ACC_W'(r_ovl)
               + dtcu_pkg::ACC_W'(r_bias);

    always_comb begin
        if (acc > Y_MAX) begin
            y_sat = Y_MAX[dtcu_pkg::SMP_W-1:0];
        end else if (acc < Y_MIN) begin
            y_sat = Y_MIN[dtcu_pkg::SMP_W-1:0];
        end else begin
            y_sat = acc[dtcu_pkg::SMP_W-1:0];
        end
    end

    // Rounded tail spans at most +-2^15, so it always fits the overlap width
    assign o_res = '{y: y_sat, ovl: tail_sum[dtcu_pkg::PROD_W:dtcu_pkg::RND_SH]};

endmodule

// ----- design/depthwise_transposed_conv_upsampler.sv -----
// Top level of the depthwise streaming transposed-convolution upsampler.
// Depends on dtcu_pkg, dtcu_if (dtcu_in_if, dtcu_out_if), dtcu_mac, assert_macros.svh.

// After reset the block zeroes the overlap memory, all 8192 entries, one entry per
// cycle, with the request side held not ready (bias_enable writes are taken anytime).
// A sample request is then issued as one beat per phase: the sequencer issues one tap
// pair per cycle while the result side is not stalled, reading the head and tail
// coefficient memories and the overlap memory at the same entry, so the single read
// port of each memory sets the rate of one output per cycle. The next request is taken
// in the cycle the last beat issues, so samples stream back to back. A coefficient or
// bias load produces no result. The first output of a sample passes the memory read
// register, the multiply register and the output register (accumulate/saturate).
// A stalled result side freezes the pipeline and, during a run, the request side.
`include "assert_macros.svh"

module depthwise_transposed_conv_upsampler (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    dtcu_in_if.sink           i_in,
    dtcu_out_if.source        o_out
);

    localparam logic [dtcu_pkg::PH_W-1:0]   K_LAST   = dtcu_pkg::PH_W'(dtcu_pkg::STRIDE - 1);
    localparam logic [dtcu_pkg::ENT_AW-1:0] CLR_LAST =
        dtcu_pkg::ENT_AW'(dtcu_pkg::ENT_DEPTH - 1);

    // Memories: head taps, tail taps, biases, overlap values
    logic signed [dtcu_pkg::SMP_W-1:0] mem_head [dtcu_pkg::ENT_DEPTH];
    logic signed [dtcu_pkg::SMP_W-1:0] mem_tail [dtcu_pkg::ENT_DEPTH];
    logic signed [dtcu_pkg::SMP_W-1:0] mem_bias [dtcu_pkg::CHANNELS];
    logic signed [dtcu_pkg::OVL_W-1:0] mem_ovl  [dtcu_pkg::ENT_DEPTH];

    dtcu_pkg::t_state r_state;
    dtcu_pkg::t_state n_state;

    logic                              r_bias_en;
    logic [dtcu_pkg::ENT_AW-1:0]       r_clr_idx;
    logic [dtcu_pkg::PH_W-1:0]         r_k;
    logic [dtcu_pkg::CH_W-1:0]         r_ch;
    logic signed [dtcu_pkg::SMP_W-1:0] r_val;

    // Stage 1: memory read data
    logic                              r_s1_valid;
    dtcu_pkg::t_beat                   r_s1_meta;
    logic signed [dtcu_pkg::SMP_W-1:0] r_s1_val;
    logic                              r_s1_bias_en;
    logic signed [dtcu_pkg::SMP_W-1:0] r_head_q;
    logic signed [dtcu_pkg::SMP_W-1:0] r_tail_q;
    logic signed [dtcu_pkg::SMP_W-1:0] r_bias_q;
    logic signed [dtcu_pkg::OVL_W-1:0] r_ovl_q;

    // Stage 2: products inside dtcu_mac
    logic                              r_s2_valid;
    dtcu_pkg::t_beat                   r_s2_meta;

    // Output register
    logic                              r_out_valid;
    dtcu_pkg::t_beat                   r_out_meta;
    logic signed [dtcu_pkg::SMP_W-1:0] r_out_y;

    logic                              in_acc;
    logic                              ch_ok;
    logic                              start_smp;
    logic                              ld_tap;
    logic                              ld_bias;
    logic                              advance;
    logic                              issue;
    logic                              k_last;
    logic                              clr_we;
    logic                              in_ready;
    logic [dtcu_pkg::ENT_AW-1:0]       rd_addr;
    logic [dtcu_pkg::ENT_AW-1:0]       ld_addr;
    logic                              ovl_we;
    logic [dtcu_pkg::ENT_AW-1:0]       ovl_waddr;
    logic signed [dtcu_pkg::OVL_W-1:0] ovl_wdata;
    dtcu_pkg::t_ops                    ops;
    dtcu_pkg::t_res                    res;

    // Request decode
    assign in_acc    = i_in.valid && in_ready;
    assign ch_ok     = 32'(i_in.channel) < dtcu_pkg::CHANNELS;
    assign start_smp = in_acc && ch_ok && (i_in.mode == dtcu_pkg::MODE_SAMPLE);
    assign ld_tap    = in_acc && ch_ok && (i_in.mode == dtcu_pkg::MODE_LOAD_TAP)
                    && (32'(i_in.tap_index) < dtcu_pkg::KTAPS);
    assign ld_bias   = in_acc && ch_ok && (i_in.mode == dtcu_pkg::MODE_LOAD_BIAS);
    assign ld_addr   = {i_in.channel, i_in.tap_index[dtcu_pkg::PH_W-1:0]};

    // Pipeline moves when the output register is free or being emptied
    assign advance = !r_out_valid || o_out.ready;
    assign k_last  = (r_k == K_LAST);
    assign rd_addr = {r_ch, r_k};

    // Configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bias_en <= 1'b0;
        end else if (i_cfg_we) begin
            r_bias_en <= i_cfg_wdata;
        end
    end

    // Sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtcu_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dtcu_pkg::ST_CLEAR: begin
                if (r_clr_idx == CLR_LAST) begin
                    n_state = dtcu_pkg::ST_IDLE;
                end
            end
            dtcu_pkg::ST_IDLE: begin
                if (start_smp) begin
                    n_state = dtcu_pkg::ST_RUN;
                end
            end
            dtcu_pkg::ST_RUN: begin
                if (advance && k_last && !start_smp) begin
                    n_state = dtcu_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = dtcu_pkg::ST_CLEAR;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        in_ready = 1'b0;
        issue    = 1'b0;
        clr_we   = 1'b0;
        unique case (r_state)
            dtcu_pkg::ST_CLEAR: begin
                clr_we = 1'b1;
            end
            dtcu_pkg::ST_IDLE: begin
                in_ready = 1'b1;
            end
            dtcu_pkg::ST_RUN: begin
                issue    = advance;
                in_ready = advance && k_last;
            end
            default: begin
                in_ready = 1'b0;
            end
        endcase
    end

    assign i_in.ready = in_ready;

    // Clear index, tap counter and held sample
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
            r_k       <= '0;
        end else begin
            if (clr_we) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
            if (start_smp) begin
                r_k <= '0;
            end else if (issue) begin
                r_k <= k_last ? '0 : r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start_smp) begin
            r_ch  <= i_in.channel;
            r_val <= i_in.sample_value;
        end
    end

    // Coefficient and bias loads
    always_ff @(posedge i_clk) begin
        if (ld_tap && !i_in.tap_index[dtcu_pkg::PH_W]) begin
            mem_head[ld_addr] <= i_in.sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_tap && i_in.tap_index[dtcu_pkg::PH_W]) begin
            mem_tail[ld_addr] <= i_in.sample_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_bias) begin
            mem_bias[i_in.channel] <= i_in.sample_value;
        end
    end

    // Overlap write port: zeroing pass, else the new tail of the beat leaving stage 2
    assign ovl_we    = clr_we || (advance && r_s2_valid);
    assign ovl_waddr = clr_we ? r_clr_idx : {r_s2_meta.ch, r_s2_meta.ph};
    assign ovl_wdata = clr_we ? '0 : res.ovl;

    always_ff @(posedge i_clk) begin
        if (ovl_we) begin
            mem_ovl[ovl_waddr] <= ovl_wdata;
        end
    end

    // Reads for the issued beat; an entry is rewritten as its beat leaves stage 2,
    // long before the next run of the same channel reads it again
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_head_q <= mem_head[rd_addr];
            r_tail_q <= mem_tail[rd_addr];
            r_ovl_q  <= mem_ovl[rd_addr];
            r_bias_q <= mem_bias[r_ch];
        end
    end

    // Beat bookkeeping through the pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_s1_valid  <= issue;
            r_s2_valid  <= r_s1_valid;
            r_out_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_meta    <= '{ch: r_ch, ph: r_k, last: k_last};
            r_s1_val     <= r_val;
            r_s1_bias_en <= r_bias_en;
            r_s2_meta    <= r_s1_meta;
            r_out_meta   <= r_s2_meta;
            r_out_y      <= res.y;
        end
    end

    // Multiply and overlap-add
    assign ops.val  = r_s1_val;
    assign ops.head = r_head_q;
    assign ops.tail = r_tail_q;
    assign ops.ovl  = r_ovl_q;
    assign ops.bias = r_s1_bias_en ? r_bias_q : '0;

    dtcu_mac u_mac (
        .i_clk (i_clk),
        .i_adv (advance),
        .i_ops (ops),
        .o_res (res)
    );

    // Result channel
    assign o_out.valid         = r_out_valid;
    assign o_out.output_sample = r_out_y;
    assign o_out.out_channel   = r_out_meta.ch;
    assign o_out.phase         = r_out_meta.ph;
    assign o_out.last_of_run   = r_out_meta.last;

    // Checks
    `ASSERT_NOW(a_clear_empty, i_clk, i_rst_n,
        r_state == dtcu_pkg::ST_CLEAR, !(r_s1_valid || r_s2_valid || r_out_valid),
        "beat in flight during overlap clearing pass")
    `ASSERT_NEXT(a_run_wraps, i_clk, i_rst_n,
        issue && k_last, r_k == '0,
        "tap counter did not restart after the last beat of a run")
    `ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n,
        r_out_valid && !o_out.ready, $stable(r_s2_meta) && $stable(r_s2_valid),
        "stage 2 moved while the output register was stalled")
    `ASSERT_NOW(a_last_flag, i_clk, i_rst_n,
        r_out_valid, r_out_meta.last == (r_out_meta.ph == K_LAST),
        "last_of_run disagrees with phase")

endmodule
